// ===== rtl/core/ukst_pkg.sv =====
// ----------------------------------------------------------------------------
// ukst_pkg: shared types and constants of the unique key set table
// Table geometry, request and status codes, controller/datapath handshake.
// ----------------------------------------------------------------------------
package ukst_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned KEY_WIDTH   = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned OP_W        = 2;
  localparam int unsigned ST_W        = 2;

  // request codes, the unused code behaves as lookup
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_DUP     = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd2;
  localparam logic [ST_W-1:0] ST_MISSING = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic start;   // capture request, rewind scan
    logic scan;    // one compare/read step
    logic shift;   // one compaction step
    logic commit;  // update table, load result register
  } ukst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ins_full;
    logic hit;
    logic miss;
    logic is_remove;
    logic shift_done;
    logic out_free;
  } ukst_stat_t;

endpackage

// ===== rtl/core/ukst_req_if.sv =====
// ----------------------------------------------------------------------------
// ukst_req_if: request channel of the unique key set table
// Valid/ready channel carrying an operation code and a key.
// ----------------------------------------------------------------------------
interface ukst_req_if import ukst_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [KEY_WIDTH-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);

endinterface

// ===== rtl/core/ukst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ukst_rsp_if: response channel of the unique key set table
// Valid/ready channel carrying status, count and position.
// ----------------------------------------------------------------------------
interface ukst_rsp_if import ukst_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] position;

  modport source (output valid, output status, output count, output position, input ready);
  modport sink   (input valid, input status, input count, input position, output ready);

endinterface

// ===== rtl/core/ukst_ram.sv =====
// ----------------------------------------------------------------------------
// ukst_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ukst_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ukst_dp.sv =====
// ----------------------------------------------------------------------------
// ukst_dp: datapath of the unique key set table
// Entry RAM, fill count, scan and shift pointers, result register.
// ----------------------------------------------------------------------------
module ukst_dp import ukst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ukst_cmd_t            cmd_i,
  output ukst_stat_t           stat_o,
  input  logic [OP_W-1:0]      op_i,
  input  logic [KEY_WIDTH-1:0] key_i,
  input  logic                 rsp_ready_i,
  output logic                 rsp_valid_o,
  output logic [ST_W-1:0]      status_o,
  output logic [CNT_W-1:0]     count_o,
  output logic [IDX_W-1:0]     position_o
);

  logic [OP_W-1:0]      op_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     rd_idx_q;
  logic                 cmp_vld_q;
  logic [IDX_W-1:0]     cmp_idx_q;
  logic                 hit_q;
  logic [IDX_W-1:0]     at_q;
  logic [CNT_W-1:0]     src_q;
  logic [IDX_W-1:0]     dst_q;
  logic                 sh_vld_q;
  logic                 rsp_valid_q;
  logic [ST_W-1:0]      status_q, status_d;
  logic [CNT_W-1:0]     rsp_count_q;
  logic [IDX_W-1:0]     position_q, position_d;

  logic                 is_ins, is_rem, ins_full;
  logic                 rd_avail, src_avail, hit_now;
  logic                 we;
  logic [IDX_W-1:0]     waddr, raddr;
  logic [KEY_WIDTH-1:0] wdata, rdata;

  assign is_ins    = (op_q == OP_INSERT);
  assign is_rem    = (op_q == OP_REMOVE);
  assign ins_full  = is_ins && (count_q == CNT_W'(TABLE_DEPTH));
  assign rd_avail  = (rd_idx_q < count_q);
  assign src_avail = (src_q < count_q);
  assign hit_now   = cmp_vld_q && (rdata == key_q);

  assign stat_o.ins_full   = ins_full;
  assign stat_o.hit        = hit_now;
  assign stat_o.miss       = !hit_now && !rd_avail;
  assign stat_o.is_remove  = is_rem;
  assign stat_o.shift_done = !sh_vld_q && !src_avail;
  assign stat_o.out_free   = !rsp_valid_q || rsp_ready_i;

  // single port pair: scan or shift reads, shift or append writes
  assign raddr = cmd_i.shift ? src_q[IDX_W-1:0] : rd_idx_q[IDX_W-1:0];
  assign we    = (cmd_i.commit && is_ins && !ins_full && !hit_q) || (cmd_i.shift && sh_vld_q);
  assign waddr = cmd_i.shift ? dst_q : count_q[IDX_W-1:0];
  assign wdata = cmd_i.shift ? rdata : key_q;

  ukst_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // result of the finished request
  always_comb begin
    status_d   = ST_OK;
    position_d = at_q;
    count_d    = count_q;
    if (is_ins) begin
      if (ins_full) begin
        status_d   = ST_FULL;
        position_d = '0;
      end else if (!hit_q) begin
        position_d = count_q[IDX_W-1:0];
        count_d    = count_q + CNT_W'(1);
      end else begin
        status_d = ST_DUP;
      end
    end else if (!hit_q) begin
      status_d   = ST_MISSING;
      position_d = '0;
    end else if (is_rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
      cmp_vld_q   <= 1'b0;
      sh_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      if (cmd_i.start) begin
        cmp_vld_q <= 1'b0;
        hit_q     <= 1'b0;
      end else if (cmd_i.scan) begin
        cmp_vld_q <= rd_avail;
        if (hit_now) begin
          hit_q    <= 1'b1;
          sh_vld_q <= 1'b0;
        end
      end else if (cmd_i.shift) begin
        sh_vld_q <= src_avail;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q     <= op_i;
      key_q    <= key_i;
      rd_idx_q <= '0;
    end
    if (cmd_i.scan) begin
      cmp_idx_q <= rd_idx_q[IDX_W-1:0];
      if (rd_avail) begin
        rd_idx_q <= rd_idx_q + CNT_W'(1);
      end
      if (hit_now) begin
        at_q  <= cmp_idx_q;
        src_q <= CNT_W'(cmp_idx_q) + CNT_W'(1);
      end
    end
    if (cmd_i.shift && src_avail) begin
      src_q <= src_q + CNT_W'(1);
      dst_q <= IDX_W'(src_q - CNT_W'(1));
    end
    if (cmd_i.commit) begin
      status_q    <= status_d;
      rsp_count_q <= count_d;
      position_q  <= position_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign status_o    = status_q;
  assign count_o     = rsp_count_q;
  assign position_o  = position_q;

endmodule

// ===== rtl/core/ukst_ctrl.sv =====
// ----------------------------------------------------------------------------
// ukst_ctrl: controller of the unique key set table
// Sequences accept, scan, compaction and result commit.
// ----------------------------------------------------------------------------
module ukst_ctrl import ukst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  ukst_stat_t stat_i,
  output ukst_cmd_t  cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.ins_full) begin
          state_d = S_DONE;
        end else begin
          cmd_o.scan = 1'b1;
          if (stat_i.hit) begin
            state_d = stat_i.is_remove ? S_SHIFT : S_DONE;
          end else if (stat_i.miss) begin
            state_d = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (stat_i.shift_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/unique_key_set_table.sv =====
// ----------------------------------------------------------------------------
// unique_key_set_table: bounded set of unique keys in insertion order
// Insert, remove and lookup on a packed table with one result per request.
// ----------------------------------------------------------------------------
// usage
//   req_i: valid/ready channel, op (insert, remove, lookup) and key
//   rsp_o: valid/ready channel, status, count after the request, position
//   one request is in work at a time; req_i.ready is high only while idle
//   the scan compares the stored keys in order and ends at the first hit or,
//   with n stored keys, at a miss after all n; accept and commit are
//   states of their own before and after the scan
//   a remove then compacts the entries behind the hit, one entry moved per
//   cycle; the slowest item is the remove of the first entry of a full table
//   an insert into a full table skips the scan
//   the rate is set by the single read port of the entry RAM, which both
//   the compare scan and the compaction pass go through
//   reset empties the table (fill count cleared) and drops any pending item
//   the result sits in an output register: the next request is accepted
//   while it waits, and a stalled rsp_o only holds the following commit
// ----------------------------------------------------------------------------
module unique_key_set_table import ukst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ukst_req_if.sink   req_i,
  ukst_rsp_if.source rsp_o
);

  ukst_cmd_t  cmd;   // controller commands
  ukst_stat_t stat;  // datapath status flags

  // sequencer: idle, scan, compaction, commit
  ukst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // entry storage, pointers and result register
  ukst_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .op_i        (req_i.op),
    .key_i       (req_i.key),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .status_o    (rsp_o.status),
    .count_o     (rsp_o.count),
    .position_o  (rsp_o.position)
  );

endmodule
